// ===== design/spq_pkg.sv =====
package spq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int TAG_BITS_DEF = 16;
   localparam int KEY_BITS     = 32;
   localparam int STATUS_BITS  = 2;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       insert;
      logic       remove;
      logic       load_rsp;
      logic       cfg_write;
      status_type status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
   } dp_stat_type;

endpackage

// ===== design/spq_if.sv =====
interface spq_req_if #(
   parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
);
   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic signed [spq_pkg::KEY_BITS-1:0] key;
   logic [TAG_BITS-1:0]               tag;

   modport source (output valid, output kind, output key, output tag, input ready);
   modport sink   (input valid, input kind, input key, input tag, output ready);
endinterface

interface spq_rsp_if #(
   parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF,
   parameter int COUNT_BITS = $clog2(spq_pkg::CAPACITY_DEF + 1)
);
   logic                                  valid;
   logic                                  ready;
   logic signed [spq_pkg::KEY_BITS-1:0]   front_key;
   logic [TAG_BITS-1:0]                   front_tag;
   logic [COUNT_BITS-1:0]                 entry_count;
   logic                                  is_empty;
   logic [spq_pkg::STATUS_BITS-1:0]       status;

   modport source (output valid, output front_key, output front_tag, output entry_count,
                   output is_empty, output status, input ready);
   modport sink   (input valid, input front_key, input front_tag, input entry_count,
                   input is_empty, input status, output ready);
endinterface

interface spq_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/spq_ctrl.sv =====
module spq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  spq_pkg::dp_stat_type stat,
   output spq_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_HOLD = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   logic      is_insert;

   assign req_ready = (state_ff == ST_IDLE) || rsp_ready;
   assign rsp_valid = (state_ff == ST_HOLD);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign is_insert = (spq_pkg::kind_type'(req_kind) == spq_pkg::KIND_INSERT);

   always_comb begin
      cmd           = '0;
      cmd.status    = spq_pkg::STATUS_OK;
      cmd.cfg_write = csr_valid;
      cmd.load_rsp  = accept;
      if (accept) begin
         if (is_insert) begin
            if (stat.full) begin
               cmd.status = spq_pkg::STATUS_FULL;
            end else begin
               cmd.insert = 1'b1;
            end
         end else begin
            if (stat.empty) begin
               cmd.status = spq_pkg::STATUS_EMPTY;
            end else begin
               cmd.remove = 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!accept && rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_no_full_insert: assert property (@(posedge clock) disable iff (reset)
      (accept && is_insert && stat.full) |-> !cmd.insert)
      else $error("insert issued on a full queue");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(cmd.insert && cmd.remove))
      else $error("insert and remove together");

   a_hold_until_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item gave no result");
`endif

endmodule

// ===== design/spq_datapath.sv =====
module spq_datapath #(
   parameter int CAPACITY   = spq_pkg::CAPACITY_DEF,
   parameter int TAG_BITS   = spq_pkg::TAG_BITS_DEF,
   parameter int COUNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spq_pkg::cmd_type                    cmd,
   output spq_pkg::dp_stat_type                stat,
   input  logic signed [spq_pkg::KEY_BITS-1:0] new_key,
   input  logic [TAG_BITS-1:0]                 new_tag,
   input  logic                                cfg_data,
   output logic signed [spq_pkg::KEY_BITS-1:0] front_key,
   output logic [TAG_BITS-1:0]                 front_tag,
   output logic [COUNT_BITS-1:0]               entry_count,
   output logic                                is_empty,
   output logic [spq_pkg::STATUS_BITS-1:0]     status
);

   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);

   logic signed [spq_pkg::KEY_BITS-1:0] key_ff [CAPACITY];
   logic signed [spq_pkg::KEY_BITS-1:0] key_in [CAPACITY];
   logic [TAG_BITS-1:0]                 tag_ff [CAPACITY];
   logic [TAG_BITS-1:0]                 tag_in [CAPACITY];
   logic [CAPACITY-1:0]                 ahead;
   logic [CAPACITY-1:0]                 lead;
   logic [COUNT_BITS-1:0]               count_ff, count_in;
   logic                                order_ff;

   logic signed [spq_pkg::KEY_BITS-1:0] front_key_ff;
   logic [TAG_BITS-1:0]                 front_tag_ff;
   logic [COUNT_BITS-1:0]               entry_count_ff;
   logic                                is_empty_ff;
   logic [spq_pkg::STATUS_BITS-1:0]     status_ff;

   assign stat.full  = (count_ff == FULL_COUNT);
   assign stat.empty = (count_ff == '0);

   // held entries need not be in the current mode's order, so only the
   // unbroken run of ahead cells from the front stays in place
   always_comb begin
      lead[0] = ahead[0];
      for (int j = 1; j < CAPACITY; j++) begin
         lead[j] = lead[j-1] && ahead[j];
      end
   end

   // each cell: does its held entry stay ahead of the incoming one
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      always_comb begin
         if (order_ff) begin
            ahead[i] = (COUNT_BITS'(i) < count_ff) && (key_ff[i] > new_key);
         end else begin
            ahead[i] = (COUNT_BITS'(i) < count_ff) && (key_ff[i] < new_key);
         end
      end

      if (i == 0) begin : g_head
         always_comb begin
            key_in[i] = key_ff[i];
            tag_in[i] = tag_ff[i];
            if (cmd.insert && !lead[i]) begin
               key_in[i] = new_key;
               tag_in[i] = new_tag;
            end else if (cmd.remove) begin
               key_in[i] = key_ff[i+1];
               tag_in[i] = tag_ff[i+1];
            end
         end
      end else if (i == CAPACITY - 1) begin : g_tail
         always_comb begin
            key_in[i] = key_ff[i];
            tag_in[i] = tag_ff[i];
            if (cmd.insert && !lead[i]) begin
               key_in[i] = lead[i-1] ? new_key : key_ff[i-1];
               tag_in[i] = lead[i-1] ? new_tag : tag_ff[i-1];
            end
         end
      end else begin : g_mid
         always_comb begin
            key_in[i] = key_ff[i];
            tag_in[i] = tag_ff[i];
            if (cmd.insert && !lead[i]) begin
               key_in[i] = lead[i-1] ? new_key : key_ff[i-1];
               tag_in[i] = lead[i-1] ? new_tag : tag_ff[i-1];
            end else if (cmd.remove) begin
               key_in[i] = key_ff[i+1];
               tag_in[i] = tag_ff[i+1];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         order_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.cfg_write) order_ff <= cfg_data;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         key_ff[i] <= key_in[i];
         tag_ff[i] <= tag_in[i];
      end
   end

   // result is taken from the post-operation front cell
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         front_key_ff   <= (count_in == '0) ? '0 : key_in[0];
         front_tag_ff   <= (count_in == '0) ? '0 : tag_in[0];
         entry_count_ff <= count_in;
         is_empty_ff    <= (count_in == '0);
         status_ff      <= cmd.status;
      end
   end

   assign front_key   = front_key_ff;
   assign front_tag   = front_tag_ff;
   assign entry_count = entry_count_ff;
   assign is_empty    = is_empty_ff;
   assign status      = status_ff;

endmodule

// ===== design/sorted_priority_queue.sv =====
// Channel  Dir  Handshake     Payload
// req_bus  in   valid/ready   kind, key, tag
// rsp_bus  out  valid/ready   front_key, front_tag, entry_count, is_empty, status
// csr_bus  in   valid/ready   data (order_mode)
//
// One item per cycle while no result waits or rsp_bus.ready is high: every cell
// compares against the new key at once and shifts in the same edge, so the
// result is registered the cycle after accept.
// Reset (synchronous) empties the queue and clears order_mode; no clearing pass.
// csr_bus is always ready.
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
   parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req_bus,
   spq_rsp_if.source rsp_bus,
   spq_csr_if.sink   csr_bus
);

   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   spq_pkg::cmd_type     cmd;
   spq_pkg::dp_stat_type stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath #(
      .CAPACITY   (CAPACITY),
      .TAG_BITS   (TAG_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .new_key     (req_bus.key),
      .new_tag     (req_bus.tag),
      .cfg_data    (csr_bus.data),
      .front_key   (rsp_bus.front_key),
      .front_tag   (rsp_bus.front_tag),
      .entry_count (rsp_bus.entry_count),
      .is_empty    (rsp_bus.is_empty),
      .status      (rsp_bus.status)
   );

endmodule
